### sv/rgbles_pkg.sv
`timescale 1ns / 1ps
package rgbles_pkg;

  localparam int unsigned LevelW = 11;
  localparam int unsigned DefTicksPerSecond = 2;

  localparam logic [LevelW-1:0] LevelFull = 11'd1024;
  localparam logic [LevelW-1:0] LevelHalf = 11'd512;
  localparam logic [LevelW-1:0] LevelOff  = 11'd0;
  localparam logic [9:0] ElapsedMax = 10'd1023;

  typedef enum logic [1:0] {
    CmdTick     = 2'd0,
    CmdSettings = 2'd1,
    CmdBlueFast = 2'd2,
    CmdBlueSlow = 2'd3
  } cmd_e;

  localparam logic [7:0] ModeSteady = 8'd0;
  localparam logic [7:0] ModeRedWhite = 8'd1;
  localparam logic [7:0] ModeGreenWhite = 8'd2;
  localparam logic [7:0] ModeYellow = 8'd3;
  localparam logic [7:0] ModeWhite = 8'd4;
  localparam logic [7:0] ModeCycle = 8'd100;
  localparam logic [7:0] ModeGreenFast = 8'd101;
  localparam logic [7:0] ModeGreenSlow = 8'd102;

  localparam logic [2:0] EffRedWhite = 3'd0;
  localparam logic [2:0] EffGreenWhite = 3'd1;
  localparam logic [2:0] EffYellow = 3'd2;
  localparam logic [2:0] EffWhite = 3'd3;
  localparam logic [2:0] EffCycle = 3'd4;
  localparam logic [2:0] EffGreen = 3'd5;
  localparam logic [2:0] EffBlue = 3'd6;

  localparam logic [7:0] LimitGreenFast = 8'd30;
  localparam logic [7:0] LimitGreenSlow = 8'd45;

  // index 0 bright, 1 red, 2 green, 3 blue
  typedef logic [3:0][LevelW-1:0] levels_t;

  function automatic levels_t mk_levels(input logic [LevelW-1:0] br, input logic [LevelW-1:0] r,
                                        input logic [LevelW-1:0] g, input logic [LevelW-1:0] b);
    levels_t v;
    v[0] = br;
    v[1] = r;
    v[2] = g;
    v[3] = b;
    return v;
  endfunction

  function automatic levels_t rom_entry(input logic [2:0] id, input logic [1:0] idx);
    levels_t v;
    v = mk_levels(LevelOff, LevelOff, LevelOff, LevelOff);
    case ({id, idx})
      {EffRedWhite, 2'd0}:   v = mk_levels(LevelFull, LevelFull, LevelOff, LevelOff);
      {EffRedWhite, 2'd1}:   v = mk_levels(LevelFull, LevelFull, LevelFull, LevelFull);
      {EffGreenWhite, 2'd0}: v = mk_levels(LevelFull, LevelOff, LevelFull, LevelOff);
      {EffGreenWhite, 2'd1}: v = mk_levels(LevelFull, LevelFull, LevelFull, LevelFull);
      {EffYellow, 2'd0}:     v = mk_levels(LevelFull, LevelFull, LevelFull, LevelOff);
      {EffWhite, 2'd0}:      v = mk_levels(LevelFull, LevelFull, LevelFull, LevelFull);
      {EffCycle, 2'd0}:      v = mk_levels(LevelFull, LevelFull, LevelOff, LevelOff);
      {EffCycle, 2'd1}:      v = mk_levels(LevelFull, LevelFull, LevelFull, LevelOff);
      {EffCycle, 2'd2}:      v = mk_levels(LevelFull, LevelOff, LevelOff, LevelFull);
      {EffGreen, 2'd0}:      v = mk_levels(LevelHalf, LevelOff, LevelOff, LevelOff);
      {EffGreen, 2'd1}:      v = mk_levels(LevelOff, LevelOff, LevelFull, LevelOff);
      {EffBlue, 2'd0}:       v = mk_levels(LevelHalf, LevelOff, LevelOff, LevelFull);
      default:               v = mk_levels(LevelOff, LevelOff, LevelOff, LevelOff);
    endcase
    return v;
  endfunction

  function automatic logic [1:0] rom_len(input logic [2:0] id);
    logic [1:0] n;
    case (id)
      EffRedWhite, EffGreenWhite, EffGreen, EffBlue: n = 2'd2;
      EffYellow, EffWhite:                           n = 2'd1;
      EffCycle:                                      n = 2'd3;
      default:                                       n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [LevelW-1:0] sat_level(input logic [LevelW-1:0] v);
    return (v > LevelFull) ? LevelFull : v;
  endfunction

endpackage

### sv/rgb_led_effect_sequencer.sv
`timescale 1ns / 1ps
// channel   dir  fields
// s_axis    in   tuser: cmd; tdata: light, mode, timeout, bright, red, green, blue
// m_axis    out  tdata: duty bright/red/green/blue, active, saved light/mode/timeout/levels
//
// one request per cycle sustained while the output is not stalled; a result becomes valid
// (input register loads at acceptance, then state update and result register load as it advances)
// reset clears the valid flags and block state, stored levels come up at full scale, duties at zero
// a stalled result holds the result register; the input register fills behind it
// and s_axis_tready_o drops only when both are occupied
module rgb_led_effect_sequencer
  import rgbles_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = DefTicksPerSecond
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // light[0], mode[8:1], timeout[16:9], bright[27:17], red[38:28], green[49:39],
  // blue[60:50], zero[63:61]
  input  logic [63:0]  s_axis_tdata_i,
  // cmd[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // duty_bright[10:0], duty_red[21:11], duty_green[32:22], duty_blue[43:33],
  // pattern_active[44], saved_light[45], saved_mode[53:46], saved_timeout[61:54],
  // saved_bright[72:62], saved_red[83:73], saved_green[94:84], saved_blue[105:95],
  // zero[111:106]
  output logic [111:0] m_axis_tdata_o
);

  localparam int unsigned LimitW = $clog2(255 * TICKS_PER_SECOND + 1);
  localparam int unsigned CmpW = (LimitW > 10) ? LimitW : 10;

  // input register
  logic        in_valid_q;
  logic [63:0] in_data_q;
  cmd_e        in_cmd_q;
  logic        advance;

  // result register
  logic         out_valid_q;
  logic [111:0] out_data_q;

  // block state
  logic       active_q, active_d;
  logic [2:0] eff_q, eff_d;
  logic [1:0] len_q, len_d;
  logic       slow_q, slow_d;
  logic [7:0] limit_q, limit_d;
  logic [9:0] elapsed_q, elapsed_d;
  logic [1:0] pos_q, pos_d;
  logic [1:0] phase_q, phase_d;
  logic       restore_q, restore_d;
  logic       light_q, light_d;
  logic [7:0] mode_q, mode_d;
  logic [7:0] tmo_q, tmo_d;
  levels_t    levels_q, levels_d;
  levels_t    duty_q, duty_d;

  // decoded request
  logic        req_light;
  logic [7:0]  req_mode;
  logic [7:0]  req_tmo;
  levels_t     req_levels;
  logic        do_update;

  logic [9:0]      elapsed_inc;
  logic [CmpW-1:0] limit_ticks;
  logic            expired;
  logic [2:0]      pos_inc;
  logic            step;

  logic       start;
  logic [2:0] start_id;
  logic       start_slow;
  logic [7:0] start_limit;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign do_update       = in_valid_q && advance;

  assign req_light     = in_data_q[0];
  assign req_mode      = in_data_q[8:1];
  assign req_tmo       = in_data_q[16:9];
  assign req_levels[0] = sat_level(in_data_q[27:17]);
  assign req_levels[1] = sat_level(in_data_q[38:28]);
  assign req_levels[2] = sat_level(in_data_q[49:39]);
  assign req_levels[3] = sat_level(in_data_q[60:50]);

  assign elapsed_inc = (elapsed_q < ElapsedMax) ? (elapsed_q + 10'd1) : elapsed_q;
  assign limit_ticks = CmpW'(limit_q) * CmpW'(TICKS_PER_SECOND);
  assign expired     = (limit_q != 8'd0) && (CmpW'(elapsed_inc) > limit_ticks);
  assign pos_inc     = {1'b0, pos_q} + 3'd1;
  assign step        = slow_q ? (phase_q == 2'd0) : !phase_q[0];

  always_comb begin
    active_d    = active_q;
    eff_d       = eff_q;
    len_d       = len_q;
    slow_d      = slow_q;
    limit_d     = limit_q;
    elapsed_d   = elapsed_q;
    pos_d       = pos_q;
    phase_d     = phase_q;
    restore_d   = restore_q;
    light_d     = light_q;
    mode_d      = mode_q;
    tmo_d       = tmo_q;
    levels_d    = levels_q;
    duty_d      = duty_q;
    start       = 1'b0;
    start_id    = EffBlue;
    start_slow  = 1'b0;
    start_limit = 8'd0;
    if (do_update) begin
      case (in_cmd_q)
        CmdTick: begin
          if (active_q) begin
            if (len_q == 2'd0) begin
              active_d = 1'b0;
            end else begin
              elapsed_d = elapsed_inc;
              if (expired) begin
                mode_d   = ModeSteady;
                light_d  = restore_q;
                duty_d   = restore_q ? levels_q : '0;
                active_d = 1'b0;
              end else if (len_q == 2'd1) begin
                duty_d = rom_entry(eff_q, 2'd0);
              end else begin
                if (step) begin
                  duty_d = rom_entry(eff_q, pos_q);
                  pos_d  = (pos_inc >= {1'b0, len_q}) ? 2'd0 : pos_inc[1:0];
                end
                phase_d = phase_q + 2'd1;
              end
            end
          end
        end
        CmdSettings: begin
          if (!req_light) begin
            duty_d    = '0;
            light_d   = 1'b0;
            mode_d    = ModeSteady;
            tmo_d     = 8'd0;
            restore_d = 1'b0;
            active_d  = 1'b0;
          end else begin
            duty_d[0] = req_levels[0];
            light_d   = 1'b1;
            mode_d    = req_mode;
            tmo_d     = req_tmo;
            case (req_mode)
              ModeSteady: begin
                restore_d = 1'b1;
                levels_d  = req_levels;
                active_d  = 1'b0;
                duty_d    = req_levels;
              end
              ModeRedWhite: begin
                start       = 1'b1;
                start_id    = EffRedWhite;
                start_limit = req_tmo;
              end
              ModeGreenWhite: begin
                start       = 1'b1;
                start_id    = EffGreenWhite;
                start_limit = req_tmo;
              end
              ModeYellow: begin
                start       = 1'b1;
                start_id    = EffYellow;
                start_limit = req_tmo;
              end
              ModeWhite: begin
                start       = 1'b1;
                start_id    = EffWhite;
                start_limit = req_tmo;
              end
              ModeCycle: begin
                start    = 1'b1;
                start_id = EffCycle;
              end
              ModeGreenFast: begin
                start       = 1'b1;
                start_id    = EffGreen;
                start_limit = LimitGreenFast;
              end
              ModeGreenSlow: begin
                start       = 1'b1;
                start_id    = EffGreen;
                start_slow  = 1'b1;
                start_limit = LimitGreenSlow;
              end
              default: begin
              end
            endcase
          end
        end
        CmdBlueFast: begin
          start    = 1'b1;
          start_id = EffBlue;
        end
        CmdBlueSlow: begin
          start      = 1'b1;
          start_id   = EffBlue;
          start_slow = 1'b1;
        end
        default: begin
        end
      endcase
      if (start) begin
        active_d  = 1'b1;
        eff_d     = start_id;
        len_d     = rom_len(start_id);
        slow_d    = start_slow;
        limit_d   = start_limit;
        elapsed_d = 10'd0;
        pos_d     = 2'd0;
        phase_d   = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
      eff_q       <= 3'd0;
      len_q       <= 2'd0;
      slow_q      <= 1'b0;
      limit_q     <= 8'd0;
      elapsed_q   <= 10'd0;
      pos_q       <= 2'd0;
      phase_q     <= 2'd0;
      restore_q   <= 1'b0;
      light_q     <= 1'b0;
      mode_q      <= 8'd0;
      tmo_q       <= 8'd0;
      levels_q    <= {4{LevelFull}};
      duty_q      <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      active_q  <= active_d;
      eff_q     <= eff_d;
      len_q     <= len_d;
      slow_q    <= slow_d;
      limit_q   <= limit_d;
      elapsed_q <= elapsed_d;
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      restore_q <= restore_d;
      light_q   <= light_d;
      mode_q    <= mode_d;
      tmo_q     <= tmo_d;
      levels_q  <= levels_d;
      duty_q    <= duty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q <= s_axis_tdata_i;
      in_cmd_q  <= cmd_e'(s_axis_tuser_i);
    end
    if (do_update) begin
      out_data_q <= {6'd0, levels_d[3], levels_d[2], levels_d[1], levels_d[0], tmo_d, mode_d,
                     light_d, active_d, duty_d[3], duty_d[2], duty_d[1], duty_d[0]};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_active_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (len_q != 2'd0))
    else $error("running pattern with zero length");

  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (pos_q < len_q))
    else $error("pattern position beyond length");

  a_restore_light : assert property (@(posedge clk_i) disable iff (!rst_ni)
    restore_q |-> light_q)
    else $error("saved colour flagged while lamp stored off");

  a_levels_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (levels_q[0] <= LevelFull) && (levels_q[1] <= LevelFull) &&
    (levels_q[2] <= LevelFull) && (levels_q[3] <= LevelFull))
    else $error("stored level above full scale");

  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !do_update |=> ($stable(duty_q) && $stable(active_q) && $stable(levels_q)))
    else $error("state changed without a request");

endmodule
